// ----- sv/boxblur_pkg.sv -----
// shared types and constants for the 3x3 rgb box blur
// no dependencies; imported by box_blur_3x3_rgb
package boxblur_pkg;

   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int FW_W        = 12;
   localparam int FH_W        = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_IDX_W   = 1;
   localparam int COUNT_W     = 4;
   localparam int SUM_W       = 12;
   localparam int NUM_W       = 13;
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 17;
   localparam int PROD_W      = NUM_W + RECIP_W;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic              op;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_end;
   } rsp_type;

   // which neighbours of the output pixel lie inside the image
   typedef struct packed {
      logic has_up;
      logic has_down;
      logic has_left;
      logic has_right;
   } border_type;

   // ceil(2^RECIP_SHIFT / (2*count)); exact floor quotient for every sum that can occur
   function automatic logic [RECIP_W-1:0] recip_of(input logic [COUNT_W-1:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd6:    r = 17'd10923;
         4'd9:    r = 17'd7282;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/box_blur_3x3_rgb.sv -----
// streaming 3x3 box blur of an rgb raster, rounded neighbourhood mean per channel
// depends on boxblur_pkg (payload types, csr codes, reciprocal table)
//
// Pixels enter in raster order, one word per clock, and the block can take a new
// word every cycle. Each output word is the rounded (half up) mean of the pixels of
// the 3x3 neighbourhood that lie inside the image, so borders and corners average
// 6 or 4 pixels, fewer in an image one pixel wide or high. Outputs trail the input
// by frame_width+1 words; after the last pixel of a frame send frame_width+1 flush
// words (op = 1) to drain them. The output word for the frame's last pixel has
// frame_end set, and the input word after the one that released it is pixel (0,0)
// of a new frame. A write to frame_width or frame_height restarts the frame; write
// them only while the block is idle. Widths outside 1..MAX_WIDTH and heights outside
// 1..MAX_HEIGHT are clamped. The two previous rows live in one line memory of
// MAX_WIDTH entries x 48 bits (one read and one write per clock); a word that
// produces an output goes through the stage 1, stage 2 and stage 3 registers and
// the output register, and the pipeline holds whenever the output register is full and not taken.
// There is no clearing pass after reset: line entries are only used once written.
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  boxblur_pkg::req_type                   req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output boxblur_pkg::rsp_type                   rsp_data,
   input  logic                                   csr_we,
   input  logic [boxblur_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [boxblur_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import boxblur_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);       // line memory address
   localparam int WCNT_W = $clog2(MAX_WIDTH + 1);   // holds the width itself
   localparam int ROW_W  = $clog2(MAX_HEIGHT);      // output row, always below height
   localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);  // holds the height itself
   localparam int IROW_W = $clog2(MAX_HEIGHT + 2);  // input row reaches height+1 during the drain

   // configuration
   logic [FW_W-1:0]   frame_width_ff;
   logic [FH_W-1:0]   frame_height_ff;
   logic [WCNT_W-1:0] w_eff;
   logic [HCNT_W-1:0] h_eff;

   // stream positions
   logic [COL_W-1:0]  in_col_ff,  in_col_in;
   logic [IROW_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;

   // handshake and pipeline control
   logic adv;
   logic accept;

   // position decode for the word being taken
   logic [WCNT_W-1:0] col_next;
   logic              row_wrap;
   logic [WCNT_W-1:0] out_col_next;
   logic [HCNT_W-1:0] out_row_next;
   logic              emit;
   logic              last;
   border_type        border;
   logic [1:0]        rows_in_img;
   logic [1:0]        cols_in_img;
   logic [PIX_W-1:0]  pix;

   // stage 1: line memory read in flight
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_ff;
   logic               s1_valid_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [PIX_W-1:0]   s1_pix_ff;
   logic               s1_emit_ff;
   logic               s1_last_ff;
   border_type         s1_border_ff;
   logic [COUNT_W-1:0] s1_count_ff;
   logic               fwd_valid_ff;
   logic [2*PIX_W-1:0] fwd_data_ff;
   logic [2*PIX_W-1:0] line_rd;
   logic [PIX_W-1:0]   up_pix;
   logic [PIX_W-1:0]   mid_pix;
   logic [2*PIX_W-1:0] wr_data;

   // stage 2: window holds the neighbourhood
   logic [PIX_W-1:0]   win_ff [9];
   logic               s2_valid_ff;
   logic               s2_last_ff;
   border_type         s2_border_ff;
   logic [COUNT_W-1:0] s2_count_ff;
   logic [8:0]         tap_ok;
   logic [SUM_W-1:0]   chan_sum [3];

   // stage 3: numerators and reciprocal
   logic               s3_valid_ff;
   logic               s3_last_ff;
   logic [NUM_W-1:0]   s3_num_ff [3];
   logic [RECIP_W-1:0] s3_recip_ff;
   logic [PROD_W-1:0]  prod [3];

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // everything moves together once the output register can take a word
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && adv;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp to 1..MAX
   always_comb begin
      if (frame_width_ff == '0)
         w_eff = WCNT_W'(1);
      else if (32'(frame_width_ff) > 32'(MAX_WIDTH))
         w_eff = WCNT_W'(MAX_WIDTH);
      else
         w_eff = WCNT_W'(frame_width_ff);

      if (frame_height_ff == '0)
         h_eff = HCNT_W'(1);
      else if (32'(frame_height_ff) > 32'(MAX_HEIGHT))
         h_eff = HCNT_W'(MAX_HEIGHT);
      else
         h_eff = HCNT_W'(frame_height_ff);
   end

   // ---------------------------------------------------------------- positions
   // the output position and its border are settled when the word is taken,
   // so a frame restart never races with words already in the pipeline
   always_comb begin
      col_next     = WCNT_W'(in_col_ff) + WCNT_W'(1);
      row_wrap     = (col_next >= w_eff);
      out_col_next = WCNT_W'(out_col_ff) + WCNT_W'(1);
      out_row_next = HCNT_W'(out_row_ff) + HCNT_W'(1);

      // first output once the centre's right and lower neighbours have arrived
      emit = ((in_row_ff >= IROW_W'(2)) ||
              ((in_row_ff == IROW_W'(1)) && (in_col_ff != '0))) &&
             (HCNT_W'(out_row_ff) < h_eff);
      last = emit && (out_row_next == h_eff) && (out_col_next == w_eff);

      border.has_up    = (out_row_ff != '0);
      border.has_down  = (out_row_next < h_eff);
      border.has_left  = (out_col_ff != '0);
      border.has_right = (out_col_next < w_eff);

      rows_in_img = 2'd1 + 2'(border.has_up) + 2'(border.has_down);
      cols_in_img = 2'd1 + 2'(border.has_left) + 2'(border.has_right);

      in_col_in  = row_wrap ? '0 : COL_W'(col_next);
      in_row_in  = row_wrap ? in_row_ff + IROW_W'(1) : in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;

      if (last) begin
         // frame complete: next word is pixel (0,0)
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (emit) begin
         if (out_col_next >= w_eff) begin
            out_col_in = '0;
            out_row_in = ROW_W'(out_row_next);
         end else begin
            out_col_in = COL_W'(out_col_next);
         end
      end

      // flush words enter as black
      if (req_data.op == OP_FLUSH)
         pix = '0;
      else
         pix = {req_data.blue_in, req_data.green_in, req_data.red_in};
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (accept) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // ---------------------------------------------------------------- line memory
   // entry = {row two above, row above} at this column; read when the word is
   // taken, written back from stage 1 as {row above, this pixel}
   always_ff @(posedge clock) begin
      if (accept)
         rd_ff <= line_mem[in_col_ff];
      if (adv && s1_valid_ff)
         line_mem[s1_col_ff] <= wr_data;
   end

   // a one-pixel-wide image reads the column that is being written at the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (adv) begin
         fwd_valid_ff <= accept && s1_valid_ff && (s1_col_ff == in_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv)
         fwd_data_ff <= wr_data;
   end

   assign line_rd = fwd_valid_ff ? fwd_data_ff : rd_ff;
   assign up_pix  = line_rd[2*PIX_W-1:PIX_W];
   assign mid_pix = line_rd[PIX_W-1:0];
   assign wr_data = {mid_pix, s1_pix_ff};

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff    <= in_col_ff;
         s1_pix_ff    <= pix;
         s1_emit_ff   <= emit;
         s1_last_ff   <= last;
         s1_border_ff <= border;
         s1_count_ff  <= COUNT_W'(rows_in_img) * COUNT_W'(cols_in_img);
      end
   end

   // ---------------------------------------------------------------- stage 2
   // window shifts for every word, output or not; oldest column on the left
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++)
            win_ff[k] <= '0;
      end else if (adv && s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]     <= win_ff[r*3 + 1];
            win_ff[r*3 + 1] <= win_ff[r*3 + 2];
         end
         win_ff[2] <= up_pix;
         win_ff[5] <= mid_pix;
         win_ff[8] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_last_ff   <= s1_last_ff;
         s2_border_ff <= s1_border_ff;
         s2_count_ff  <= s1_count_ff;
      end
   end

   // masked sums over the in-image taps
   always_comb begin
      logic [2:0] row_ok;
      logic [2:0] col_ok;
      row_ok = {s2_border_ff.has_down, 1'b1, s2_border_ff.has_up};
      col_ok = {s2_border_ff.has_right, 1'b1, s2_border_ff.has_left};
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            tap_ok[r*3 + c] = row_ok[r] & col_ok[c];
      for (int ch = 0; ch < 3; ch++) begin
         chan_sum[ch] = '0;
         for (int k = 0; k < 9; k++)
            chan_sum[ch] = chan_sum[ch] +
                           (tap_ok[k] ? SUM_W'(win_ff[k][ch*CHAN_W +: CHAN_W]) : '0);
      end
   end

   // ---------------------------------------------------------------- stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // numerator 2*sum + count, divided below by 2*count through its reciprocal
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_last_ff  <= s2_last_ff;
         s3_recip_ff <= recip_of(s2_count_ff);
         for (int ch = 0; ch < 3; ch++)
            s3_num_ff[ch] <= {chan_sum[ch], 1'b0} + NUM_W'(s2_count_ff);
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++)
         prod[ch] = PROD_W'(s3_num_ff[ch]) * PROD_W'(s3_recip_ff);
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.red_out   <= prod[0][RECIP_SHIFT +: CHAN_W];
         rsp_data_ff.green_out <= prod[1][RECIP_SHIFT +: CHAN_W];
         rsp_data_ff.blue_out  <= prod[2][RECIP_SHIFT +: CHAN_W];
         rsp_data_ff.frame_end <= s3_last_ff;
      end
   end

endmodule

// ----- bench/box_blur_3x3_rgb_test.sv -----
`timescale 1ns / 100ps
// self-checking bench for box_blur_3x3_rgb: streams pixel words and checks each blurred word
// depends on boxblur_pkg and box_blur_3x3_rgb
module box_blur_3x3_rgb_test;
   import boxblur_pkg::*;

   localparam int LINE_DEPTH  = 2048;
   localparam int ROWS_MAX    = 4096;
   // an output passes the block's stage and output registers; a little margin on top
   localparam int PIPE_SLACK  = 8;
   localparam int CYCLE_LIMIT = 500000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   box_blur_3x3_rgb #(
      .MAX_WIDTH  (LINE_DEPTH),
      .MAX_HEIGHT (ROWS_MAX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the block: raw registers, the two previous rows, the 3x3 window
   // and where the input and output streams stand in the frame
   logic [FW_W-1:0]  width_reg;
   logic [FH_W-1:0]  height_reg;
   logic [PIX_W-1:0] upper_row  [LINE_DEPTH];
   logic [PIX_W-1:0] middle_row [LINE_DEPTH];
   logic [PIX_W-1:0] nbhd [9];
   int unsigned      in_col, in_line, out_col, out_line;

   // blurred words still owed by the block, oldest first
   rsp_type          expected_means [$];
   rsp_type          oldest_mean;

   int unsigned      errors = 0;
   int unsigned      words_sent = 0;
   int unsigned      cycles = 0;
   int unsigned      send_idle_pct;
   int unsigned      recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   // out-of-range register values are clamped by the block
   function automatic int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
   endfunction

   function automatic int unsigned active_height();
      if (height_reg == 0) return 1;
      if (height_reg > ROWS_MAX) return ROWS_MAX;
      return height_reg;
   endfunction

   function automatic void restart_frame();
      in_col   = 0;
      in_line  = 0;
      out_col  = 0;
      out_line = 0;
   endfunction

   function automatic void reset_shadow();
      width_reg  = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      // unwritten line entries only ever feed masked neighbours
      foreach (upper_row[i]) upper_row[i] = '0;
      foreach (middle_row[i]) middle_row[i] = '0;
      foreach (nbhd[i]) nbhd[i] = '0;
      restart_frame();
   endfunction

   // either register write puts the frame back to pixel (0,0)
   function automatic void shadow_write(input logic [CSR_IDX_W-1:0] idx,
                                        input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_FRAME_WIDTH:  width_reg  = value[FW_W-1:0];
         REG_FRAME_HEIGHT: height_reg = value[FH_W-1:0];
         default: ;
      endcase
      restart_frame();
   endfunction

   // advance the shadow by one accepted word; queue the blurred word it releases, if any
   function automatic void predict_blur(input req_type w);
      int unsigned      wd, ht, col, cnt, yr, xc, r, c;
      int unsigned      sum_r, sum_g, sum_b;
      logic [PIX_W-1:0] pix, up, mid, p;
      logic             produces, last;
      rsp_type          res;
      wd  = active_width();
      ht  = active_height();
      col = in_col;
      if (col >= wd) col = 0;
      // flush words move the stream on like a black pixel; packed as {blue, green, red}
      pix = (w.op == OP_FLUSH) ? '0 : {w.blue_in, w.green_in, w.red_in};
      up  = upper_row[col];
      mid = middle_row[col];
      upper_row[col]  = mid;
      middle_row[col] = pix;
      for (r = 0; r < 3; r++) begin
         nbhd[r * 3]     = nbhd[r * 3 + 1];
         nbhd[r * 3 + 1] = nbhd[r * 3 + 2];
      end
      nbhd[2] = up;
      nbhd[5] = mid;
      nbhd[8] = pix;
      // an output needs the word right below-right of its pixel
      produces = (in_line >= 2) || (in_line == 1 && col >= 1);
      if (col + 1 >= wd) begin
         in_col = 0;
         in_line++;
      end else begin
         in_col = col + 1;
      end
      if (!produces || out_line >= ht) return;
      // window centre is the pixel at (out_line, out_col); skip neighbours off the image
      cnt   = 0;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (r = 0; r < 3; r++) begin
         yr = out_line + r;
         if (yr < 1 || yr > ht) continue;
         for (c = 0; c < 3; c++) begin
            xc = out_col + c;
            if (xc < 1 || xc > wd) continue;
            p = nbhd[r * 3 + c];
            sum_r += p[7:0];
            sum_g += p[15:8];
            sum_b += p[23:16];
            cnt++;
         end
      end
      if (cnt == 0) cnt = 1;
      // round half up without division by a fraction
      res.red_out   = CHAN_W'((2 * sum_r + cnt) / (2 * cnt));
      res.green_out = CHAN_W'((2 * sum_g + cnt) / (2 * cnt));
      res.blue_out  = CHAN_W'((2 * sum_b + cnt) / (2 * cnt));
      last = (out_line + 1 == ht) && (out_col + 1 == wd);
      res.frame_end = last;
      expected_means.push_back(res);
      if (last) begin
         restart_frame();
      end else if (out_col + 1 >= wd) begin
         out_col = 0;
         out_line++;
      end else begin
         out_col++;
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void compare_field(input string name, input logic [CHAN_W-1:0] want,
                                         input logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // every taken output word is matched against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_means.size() == 0) begin
            $display("%0t: blurred word %h with nothing owed", $time, rsp_data);
            errors++;
         end else begin
            oldest_mean = expected_means.pop_front();
            compare_field("red_out", oldest_mean.red_out, rsp_data.red_out);
            compare_field("green_out", oldest_mean.green_out, rsp_data.green_out);
            compare_field("blue_out", oldest_mean.blue_out, rsp_data.blue_out);
            compare_field("frame_end", CHAN_W'(oldest_mean.frame_end),
                          CHAN_W'(rsp_data.frame_end));
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   function automatic req_type pixel_word(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                          input logic [CHAN_W-1:0] b);
      req_type w;
      w.op       = OP_PIXEL;
      w.red_in   = r;
      w.green_in = g;
      w.blue_in  = b;
      return w;
   endfunction

   // levels lean toward the extremes
   function automatic logic [CHAN_W-1:0] random_level();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   // flush words carry junk colour that must not count
   function automatic req_type flush_word();
      req_type w;
      w    = pixel_word(random_level(), random_level(), random_level());
      w.op = OP_FLUSH;
      return w;
   endfunction

   // an in-frame word, now and then a flush that stands in as black
   function automatic req_type random_pixel();
      if ($urandom_range(0, 99) < 3) return flush_word();
      return pixel_word(random_level(), random_level(), random_level());
   endfunction

   // past the frame's last pixel a pixel word acts like a flush
   function automatic req_type drain_word();
      if ($urandom_range(0, 3) == 0)
         return pixel_word(random_level(), random_level(), random_level());
      return flush_word();
   endfunction

   // present one word, with random gaps before it; valid stays up into the next word
   task automatic send_word(input req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_blur(w);
      words_sent++;
   endtask

   // stop sending until every owed word is out, then give the pipeline some slack
   task automatic hold_until_drained(input int unsigned slack);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_means.size() != 0) @(posedge clock);
      repeat (slack) @(posedge clock);
   endtask

   // only called while idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      shadow_write(idx, value);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // one frame at the current geometry plus its drain words; optionally broken off early
   task automatic send_frame(input bit cut_short);
      int unsigned wd, ht, total, stop, i;
      wd    = active_width();
      ht    = active_height();
      total = wd * ht;
      stop  = cut_short ? $urandom_range(0, total + wd) : total + wd + 1;
      for (i = 0; i < stop; i++) begin
         if ($urandom_range(0, 299) == 0) hold_until_drained(0);
         send_word(i < total ? random_pixel() : drain_word());
      end
   endtask

   // ---------------------------------------------------------------- tests

   // default 640 x 480 geometry straight out of reset, a partial frame
   task automatic test_reset_geometry();
      repeat (700) send_word(random_pixel());
      hold_until_drained(PIPE_SLACK);
   endtask

   // tiny hand-built images
   task automatic test_small_frames();
      logic [CHAN_W-1:0] reds   [9] = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd9, 8'd127, 8'd254, 8'd3, 8'd0};
      logic [CHAN_W-1:0] greens [9] = '{8'd0, 8'd255, 8'd2, 8'd1, 8'd9, 8'd0, 8'd255, 8'd170, 8'd85};
      logic [CHAN_W-1:0] blues  [9] = '{8'd1, 8'd1, 8'd0, 8'd0, 8'd9, 8'd255, 8'd255, 8'd0, 8'd255};
      int unsigned       i;
      // single pixel: both registers written as zero, which the block treats as one
      write_reg(REG_FRAME_WIDTH, '0);
      write_reg(REG_FRAME_HEIGHT, '0);
      send_word(pixel_word('1, '1, '1));
      send_word(flush_word());
      send_word(flush_word());
      hold_until_drained(PIPE_SLACK);
      // only the low 12 bits of the write reach frame_width, so this is a 2 x 1 image
      write_reg(REG_FRAME_WIDTH, 13'h1002);
      write_reg(REG_FRAME_HEIGHT, 13'd1);
      send_word(pixel_word(8'd0, 8'd255, 8'd1));
      send_word(pixel_word(8'd255, 8'd0, 8'd2));
      send_word(flush_word());
      send_word(pixel_word(8'h5a, 8'ha5, 8'hff));
      send_word(flush_word());
      hold_until_drained(PIPE_SLACK);
      // 3 x 3: corners, edges and a full centre; the middle pixel comes as a flush word
      write_reg(REG_FRAME_WIDTH, 13'd3);
      write_reg(REG_FRAME_HEIGHT, 13'd3);
      for (i = 0; i < 9; i++)
         send_word(i == 4 ? flush_word() : pixel_word(reds[i], greens[i], blues[i]));
      send_word(pixel_word('1, '1, '1));
      send_word(flush_word());
      send_word(flush_word());
      send_word(flush_word());
      hold_until_drained(PIPE_SLACK);
   endtask

   // all-ones width clamps to the line store depth; the start of one wide row
   task automatic test_widest_row();
      write_reg(REG_FRAME_WIDTH, 13'h0fff);
      write_reg(REG_FRAME_HEIGHT, 13'd1);
      repeat (150) send_word(random_pixel());
      hold_until_drained(PIPE_SLACK);
   endtask

   // all-ones height clamps to the row limit; the top of one tall column
   task automatic test_tallest_column();
      write_reg(REG_FRAME_HEIGHT, '1);
      write_reg(REG_FRAME_WIDTH, 13'd1);
      repeat (150) send_word(random_pixel());
      hold_until_drained(PIPE_SLACK);
   endtask

   // random small geometries, frames back to back, now and then one broken off
   task automatic test_random_frames(input int unsigned count);
      int unsigned target, groups, g, raw_w, raw_h;
      target = words_sent + count;
      while (words_sent < target) begin
         case ($urandom_range(0, 9))
            0:       raw_w = 0;
            1:       raw_w = $urandom_range(13, 48);
            default: raw_w = $urandom_range(1, 12);
         endcase
         raw_h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 1)) begin
            write_reg(REG_FRAME_WIDTH, CSR_DATA_W'(raw_w));
            write_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(raw_h));
         end else begin
            write_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(raw_h));
            write_reg(REG_FRAME_WIDTH, CSR_DATA_W'(raw_w));
         end
         groups = $urandom_range(1, 3);
         for (g = 1; g <= groups; g++)
            send_frame(g == groups && $urandom_range(0, 7) == 0);
         hold_until_drained(PIPE_SLACK);
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset_shadow();
      // light sender gaps, heavy receiver stalls
      send_idle_pct = 6;
      recv_idle_pct = 51;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_small_frames();
      test_random_frames(350);
      // heavy sender gaps, light receiver stalls
      send_idle_pct = 51;
      recv_idle_pct = 6;
      test_widest_row();
      test_random_frames(350);
      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_tallest_column();
      test_random_frames(350);
      hold_until_drained(PIPE_SLACK);
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_means.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
